[rtl/core/assert_macros.svh]
// Assertion macros used by the checker module of the core.
// Depends on signals named clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CVYR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define CVYR_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/core/cvyr_pkg.sv]
// Shared constants, types and arithmetic helpers of the pose core.
// No dependencies; imported by the core, the rotation pipeline and the checker.
package cvyr_pkg;

	// Number of rotation stages in the sine and cosine pipeline.
	localparam int CORDIC_STAGES = 18;
	// Cycles from an accepted request to its result strobe.
	localparam int LATENCY = CORDIC_STAGES + 15;

	// Angle constants in Q.24 radians.
	localparam logic [26:0] TWO_PI_Q24  = 27'd105414357;
	localparam logic [26:0] PI_Q24      = 27'd52707179;
	localparam logic [26:0] HALF_PI_Q24 = 27'd26353589;
	// Rotation gain in Q.30, loaded as the starting x.
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

	// floor(2^41 / 15625): reciprocal for the microsecond-to-second scale.
	localparam logic [27:0] RECIP_US = 28'd140737488;
	// floor(2^35 / (2*pi in Q.24)): reciprocal for the angle reduction.
	localparam logic [8:0] RECIP_TWO_PI = 9'd325;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_VEL_X    = 2'd0,
		REG_VEL_Y    = 2'd1,
		REG_YAW_RATE = 2'd2,
		REG_START_US = 2'd3
	} reg_idx_t;

	// Values computed early that travel alongside the rotation pipeline.
	typedef struct packed {
		logic signed [31:0] t;
		logic signed [31:0] yaw;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} side_t;

	// Arctangent of 2^-i in Q.24.
	function automatic logic [27:0] atan_q24(input int i);
		logic [27:0] v;
		unique case (i)
			0: v = 28'd13176795;
			1: v = 28'd7778716;
			2: v = 28'd4110060;
			3: v = 28'd2086331;
			4: v = 28'd1047214;
			5: v = 28'd524117;
			6: v = 28'd262123;
			7: v = 28'd131069;
			8: v = 28'd65536;
			default: v = (i <= 24) ? (28'd1 << (24 - i)) : 28'd0;
		endcase
		return v;
	endfunction

	// Right shift with rounding to nearest, ties away from zero.
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
		input int n);
		logic signed [63:0] half;
		half = 64'sd1 <<< (n - 1);
		if (x >= 0) begin
			return (x + half) >>> n;
		end else begin
			return -((-x + half) >>> n);
		end
	endfunction

	// Saturate to the signed 32-bit range.
	function automatic logic signed [31:0] sat_s32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// Saturate to the signed 24-bit range.
	function automatic logic signed [23:0] sat_s24(input logic signed [63:0] x);
		logic signed [23:0] r;
		if (x > 64'sd8388607) begin
			r = 24'sh7fffff;
		end else if (x < -64'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = x[23:0];
		end
		return r;
	endfunction

endpackage

[rtl/core/cvyr_cordic.sv]
// Pipelined rotation-mode CORDIC: one stage per iteration, then rounding to Q1.16.
// Depends on cvyr_pkg for the stage count, gain, arctangent table and side type.
module cvyr_cordic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  logic signed [27:0]    in_z,
	input  logic                  in_neg,
	input  cvyr_pkg::side_t       in_side,
	output logic                  out_vld,
	output logic signed [17:0]    out_cos,
	output logic signed [17:0]    out_sin,
	output cvyr_pkg::side_t       out_side
);
	import cvyr_pkg::*;

	// Stage k holds the state after k iterations; stage 0 is the input.
	logic                  vld_s  [0:CORDIC_STAGES];
	logic signed [33:0]    x_s    [0:CORDIC_STAGES];
	logic signed [33:0]    y_s    [0:CORDIC_STAGES];
	logic signed [27:0]    z_s    [0:CORDIC_STAGES];
	logic                  neg_s  [0:CORDIC_STAGES];
	side_t                 side_s [0:CORDIC_STAGES];

	logic signed [63:0]    xr;
	logic signed [63:0]    yr;
	logic signed [17:0]    xc;
	logic signed [17:0]    yc;

	assign vld_s[0]  = in_vld;
	assign x_s[0]    = GAIN_Q30;
	assign y_s[0]    = 34'sd0;
	assign z_s[0]    = in_z;
	assign neg_s[0]  = in_neg;
	assign side_s[0] = in_side;

	// One micro-rotation per stage, direction taken from the residual angle.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		localparam logic signed [27:0] ATAN = signed'(atan_q24(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ATAN;
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ATAN;
			end
			neg_s[i+1]  <= neg_s[i];
			side_s[i+1] <= side_s[i];
		end
	end

	// Round Q.30 to Q.16 and clamp to plus or minus one.
	always_comb begin
		xr = rnd_shift(64'(x_s[CORDIC_STAGES]), 14);
		yr = rnd_shift(64'(y_s[CORDIC_STAGES]), 14);
		if (xr > 64'sd65536) begin
			xc = 18'sd65536;
		end else if (xr < -64'sd65536) begin
			xc = -18'sd65536;
		end else begin
			xc = xr[17:0];
		end
		if (yr > 64'sd65536) begin
			yc = 18'sd65536;
		end else if (yr < -64'sd65536) begin
			yc = -18'sd65536;
		end else begin
			yc = yr[17:0];
		end
	end

	// Output register; the half-turn fold flips both signs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		out_cos  <= neg_s[CORDIC_STAGES] ? -xc : xc;
		out_sin  <= neg_s[CORDIC_STAGES] ? -yc : yc;
		out_side <= side_s[CORDIC_STAGES];
	end

endmodule

[rtl/core/const_velocity_yaw_rate_pose_core.sv]
// Top level of the constant-velocity, constant-yaw-rate pose core.
// Depends on cvyr_pkg and the rotation pipeline cvyr_cordic.
//
// Channel   Ports                                  Accepted when
// request   start, busy, timestamp_us              start high at a rising edge (busy is low)
// result    done, elapsed_s .. dvy_dyaw_rate       done high for one cycle
// config    cfg_we, cfg_idx, cfg_data              cfg_we high at a rising edge
//
// A request may enter every cycle; its result passes through the input stages,
// the rotation pipeline and the output stages before done is raised.
// busy stays low: the pipeline never stalls, and the receiver takes every result.
// Reset clears the valid bits and the configuration registers; data registers keep
// whatever they held.
module const_velocity_yaw_rate_pose_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [61:0]        timestamp_us,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [61:0]        cfg_data,
	output logic               done,
	output logic signed [31:0] elapsed_s,
	output logic signed [31:0] yaw,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [23:0] body_vel_x,
	output logic signed [23:0] body_vel_y,
	output logic signed [17:0] cos_yaw,
	output logic signed [17:0] sin_yaw,
	output logic signed [31:0] dvx_dyaw_rate,
	output logic signed [31:0] dvy_dyaw_rate
);
	import cvyr_pkg::*;

	// Configuration registers.
	logic signed [23:0] vel_x_q;
	logic signed [23:0] vel_y_q;
	logic signed [23:0] yaw_rate_q;
	logic [61:0]        start_us_q;

	// Valid bits of the stages before and after the rotation pipeline.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic vld_s11, vld_s12, vld_s13;

	// Elapsed-time stages.
	logic signed [62:0] diff;
	logic [62:0]        dmag;
	logic [27:0]        m_s1, m_s2, m_s3, m_s4;
	logic               sgn_s1, sgn_s2, sgn_s3, sgn_s4;
	logic [40:0]        n2_s2, n2_s3, n2_s4;
	logic [48:0]        phi_s3;
	logic [47:0]        plo_s3;
	logic [68:0]        psum;
	logic [27:0]        q0_s4;
	logic [40:0]        rem_us;
	logic [27:0]        qt;
	logic [32:0]        tmag;
	logic signed [31:0] t_s5, t_s6;

	// Product and angle reduction stages.
	logic signed [55:0] pyaw_s6, ppx_s6, ppy_s6;
	logic signed [35:0] rot_s7;
	side_t              side_s7, side_s8, side_s9, side_s10;
	logic [34:0]        rabs;
	logic [43:0]        rprod;
	logic [34:0]        rmag_s8;
	logic               rsgn_s8;
	logic [8:0]         rq_s8;
	logic [34:0]        rr0, rr1;
	logic signed [27:0] rem_s9;
	logic signed [27:0] r1;
	logic signed [27:0] z_s10;
	logic               neg_s10;

	// Stages after the rotation pipeline.
	logic               cvld;
	logic signed [17:0] ccos, csin;
	side_t              cside;
	logic signed [41:0] vxc_s11, vys_s11, vyc_s11, vxs_s11;
	logic signed [17:0] cos_s11, cos_s12, cos_s13;
	logic signed [17:0] sin_s11, sin_s12, sin_s13;
	side_t              side_s11, side_s12, side_s13;
	logic signed [63:0] bvx_full, bvy_full;
	logic signed [26:0] bvy_s12, nbvx_s12;
	logic signed [23:0] bvxo_s12, bvyo_s12, bvxo_s13, bvyo_s13;
	logic signed [58:0] jy_s13, jx_s13;

	assign busy = 1'b0;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_x_q    <= '0;
			vel_y_q    <= '0;
			yaw_rate_q <= '0;
			start_us_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_VEL_X:    vel_x_q    <= cfg_data[23:0];
				REG_VEL_Y:    vel_y_q    <= cfg_data[23:0];
				REG_YAW_RATE: yaw_rate_q <= cfg_data[23:0];
				REG_START_US: start_us_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5} <= '0;
			{vld_s6, vld_s7, vld_s8, vld_s9, vld_s10} <= '0;
			{vld_s11, vld_s12, vld_s13, done} <= '0;
		end else begin
			vld_s1  <= start && !busy;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= cvld;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			done    <= vld_s13;
		end
	end

	// Stage 1: signed microsecond difference. Magnitudes beyond 2^27 saturate
	// the elapsed time anyway, so the magnitude clamps there.
	assign diff = signed'({1'b0, timestamp_us}) - signed'({1'b0, start_us_q});
	assign dmag = diff[62] ? 63'(-diff) : 63'(diff);

	always_ff @(posedge clk) begin
		sgn_s1 <= diff[62];
		m_s1   <= (dmag > 63'd134217728) ? 28'd134217728 : dmag[27:0];
	end

	// Stages 2 to 5: t = 16*m + round(12144*m / 15625), the fraction by reciprocal
	// multiply in two partial products and one correction step.
	assign psum   = {phi_s3, 20'd0} + 69'(plo_s3);
	assign rem_us = n2_s4 - 41'(q0_s4) * 41'd15625;
	assign qt     = (rem_us >= 41'd15625) ? q0_s4 + 28'd1 : q0_s4;
	assign tmag   = (33'(m_s4) << 4) + 33'(qt);

	always_ff @(posedge clk) begin
		n2_s2  <= 41'(m_s1) * 41'd12144 + 41'd7812;
		m_s2   <= m_s1;
		sgn_s2 <= sgn_s1;

		phi_s3 <= 49'(n2_s2[40:20]) * 49'(RECIP_US);
		plo_s3 <= 48'(n2_s2[19:0]) * 48'(RECIP_US);
		n2_s3  <= n2_s2;
		m_s3   <= m_s2;
		sgn_s3 <= sgn_s2;

		q0_s4  <= psum[68:41];
		n2_s4  <= n2_s3;
		m_s4   <= m_s3;
		sgn_s4 <= sgn_s3;

		if (!sgn_s4) begin
			t_s5 <= (tmag > 33'd2147483647) ? 32'sh7fffffff : tmag[31:0];
		end else begin
			t_s5 <= (tmag > 33'd2147483648) ? 32'sh80000000 : 32'd0 - tmag[31:0];
		end
	end

	// Stages 6 and 7: yaw and position products, then rounding and saturation.
	always_ff @(posedge clk) begin
		pyaw_s6 <= 56'(yaw_rate_q) * 56'(t_s5);
		ppx_s6  <= 56'(vel_x_q) * 56'(t_s5);
		ppy_s6  <= 56'(vel_y_q) * 56'(t_s5);
		t_s6    <= t_s5;

		rot_s7        <= 36'(rnd_shift(64'(pyaw_s6), 20));
		side_s7.t     <= t_s6;
		side_s7.yaw   <= sat_s32(rnd_shift(64'(pyaw_s6), 20));
		side_s7.pos_x <= sat_s32(rnd_shift(64'(ppx_s6), 24));
		side_s7.pos_y <= sat_s32(rnd_shift(64'(ppy_s6), 24));
	end

	// Stages 8 to 10: remainder of the yaw by 2*pi (truncating, sign of the yaw),
	// then fold into [-pi, pi] and into [-pi/2, pi/2].
	assign rabs  = rot_s7[35] ? 35'(-rot_s7) : 35'(rot_s7);
	assign rprod = 44'(rabs) * 44'(RECIP_TWO_PI);
	assign rr0   = rmag_s8 - 35'(rq_s8) * 35'(TWO_PI_Q24);
	assign rr1   = (rr0 >= 35'(TWO_PI_Q24)) ? rr0 - 35'(TWO_PI_Q24) : rr0;

	always_comb begin
		if (rem_s9 > signed'({1'b0, PI_Q24})) begin
			r1 = rem_s9 - signed'({1'b0, TWO_PI_Q24});
		end else if (rem_s9 < -signed'({1'b0, PI_Q24})) begin
			r1 = rem_s9 + signed'({1'b0, TWO_PI_Q24});
		end else begin
			r1 = rem_s9;
		end
	end

	always_ff @(posedge clk) begin
		rmag_s8 <= rabs;
		rsgn_s8 <= rot_s7[35];
		rq_s8   <= rprod[43:35];
		side_s8 <= side_s7;

		rem_s9  <= rsgn_s8 ? -28'(rr1) : 28'(rr1);
		side_s9 <= side_s8;

		priority if (r1 > signed'({1'b0, HALF_PI_Q24})) begin
			z_s10   <= r1 - signed'({1'b0, PI_Q24});
			neg_s10 <= 1'b1;
		end else if (r1 < -signed'({1'b0, HALF_PI_Q24})) begin
			z_s10   <= r1 + signed'({1'b0, PI_Q24});
			neg_s10 <= 1'b1;
		end else begin
			z_s10   <= r1;
			neg_s10 <= 1'b0;
		end
		side_s10 <= side_s9;
	end

	// Cosine and sine of the reduced angle.
	cvyr_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s10),
		.in_z     (z_s10),
		.in_neg   (neg_s10),
		.in_side  (side_s10),
		.out_vld  (cvld),
		.out_cos  (ccos),
		.out_sin  (csin),
		.out_side (cside)
	);

	// Stages 11 and 12: velocity rotated into the body frame.
	assign bvx_full = rnd_shift(64'(vxc_s11) + 64'(vys_s11), 16);
	assign bvy_full = rnd_shift(64'(vyc_s11) - 64'(vxs_s11), 16);

	always_ff @(posedge clk) begin
		vxc_s11  <= 42'(vel_x_q) * 42'(ccos);
		vys_s11  <= 42'(vel_y_q) * 42'(csin);
		vyc_s11  <= 42'(vel_y_q) * 42'(ccos);
		vxs_s11  <= 42'(vel_x_q) * 42'(csin);
		cos_s11  <= ccos;
		sin_s11  <= csin;
		side_s11 <= cside;

		bvy_s12  <= bvy_full[26:0];
		nbvx_s12 <= 27'(-bvx_full);
		bvxo_s12 <= sat_s24(bvx_full);
		bvyo_s12 <= sat_s24(bvy_full);
		cos_s12  <= cos_s11;
		sin_s12  <= sin_s11;
		side_s12 <= side_s11;
	end

	// Stage 13: Jacobian products; stage 14: rounding into the result registers.
	always_ff @(posedge clk) begin
		jy_s13   <= 59'(bvy_s12) * 59'(side_s12.t);
		jx_s13   <= 59'(nbvx_s12) * 59'(side_s12.t);
		bvxo_s13 <= bvxo_s12;
		bvyo_s13 <= bvyo_s12;
		cos_s13  <= cos_s12;
		sin_s13  <= sin_s12;
		side_s13 <= side_s12;

		elapsed_s     <= side_s13.t;
		yaw           <= side_s13.yaw;
		pos_x         <= side_s13.pos_x;
		pos_y         <= side_s13.pos_y;
		body_vel_x    <= bvxo_s13;
		body_vel_y    <= bvyo_s13;
		cos_yaw       <= cos_s13;
		sin_yaw       <= sin_s13;
		dvx_dyaw_rate <= sat_s32(rnd_shift(64'(jy_s13), 24));
		dvy_dyaw_rate <= sat_s32(rnd_shift(64'(jx_s13), 24));
	end

endmodule

[rtl/core/cvyr_checker.sv]
// Port-level checks of the pose core, attached to it by a bind statement.
// Depends on cvyr_pkg for the latency and on assert_macros.svh.
`include "assert_macros.svh"

module cvyr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [31:0] elapsed_s,
	input logic signed [31:0] yaw,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] pos_y,
	input logic signed [17:0] cos_yaw,
	input logic signed [17:0] sin_yaw
);
	import cvyr_pkg::*;

	logic trig_ok;

	// Cosine and sine both lie within plus or minus one.
	assign trig_ok = (cos_yaw <= 18'sd65536) && (cos_yaw >= -18'sd65536)
		&& (sin_yaw <= 18'sd65536) && (sin_yaw >= -18'sd65536);

	// The pipeline never pushes back on requests.
	`CVYR_NEVER(a_never_busy, busy, "busy raised")
	// Every accepted request yields a result after the fixed latency.
	`CVYR_ASSERT(a_latency, (start && !busy) |-> ##LATENCY done, "result missing")
	// Cosine and sine stay within plus or minus one.
	`CVYR_ASSERT(a_trig_range, done |-> trig_ok, "trig out of range")
	// No elapsed time means no motion and no rotation.
	`CVYR_ASSERT(a_zero_time, (done && elapsed_s == 0) |-> (yaw == 0 && pos_x == 0 && pos_y == 0), "motion at zero time")

endmodule

bind const_velocity_yaw_rate_pose_core cvyr_checker u_cvyr_checker (.*);
